[hw/rtl/ptm_pkg.sv]
// Shared constants, types and helper functions of the polyphonic triangle mixer.
package ptm_pkg;

   localparam int NOTE_COUNT   = 12;
   localparam int STEP_COUNT   = 12;
   localparam int ACTIVE_NOTES = (NOTE_COUNT < STEP_COUNT) ? NOTE_COUNT : STEP_COUNT;
   localparam int LANE_COUNT   = 2 * ACTIVE_NOTES;

   localparam int KEY_W    = 12;
   localparam int OCT_W    = 4;
   localparam int VOL_W    = 4;
   localparam int SAMPLE_W = 8;
   localparam int PHASE_W  = 32;
   localparam int WAVE_W   = 8;

   localparam int WAVE_SPAN = 128;
   localparam int MAG_W     = $clog2(LANE_COUNT * WAVE_SPAN + 1);
   localparam int SUM_W     = MAG_W + 1;
   localparam int CNT_W     = $clog2(LANE_COUNT + 1);

   localparam int GROUP_SIZE  = 4;
   localparam int GROUP_COUNT = (LANE_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GSUM_W      = WAVE_W + $clog2(GROUP_SIZE);
   localparam int GCNT_W      = $clog2(GROUP_SIZE + 1);

   localparam logic [OCT_W-1:0] OCT_CENTER = OCT_W'(4);
   localparam logic [VOL_W-1:0] MAX_VOLUME = VOL_W'(8);
   localparam int SAMPLE_MID = 128;
   localparam int SAMPLE_MAX = 255;

   localparam logic [PHASE_W-1:0] STEP_TABLE [STEP_COUNT] = '{
      32'd51076057, 32'd54113197, 32'd57330935, 32'd60740010,
      32'd64351799, 32'd68178356, 32'd72232452, 32'd76527617,
      32'd81078186, 32'd85899346, 32'd91007187, 32'd96418756
   };

   typedef struct packed {
      logic               done;
      logic [SUM_W-1:0]   sum;
      logic [CNT_W-1:0]   voices;
   } merge_result_type;

   typedef struct packed {
      logic               done;
      logic [MAG_W-1:0]   quotient;
   } div_result_type;

   // Remote notes use the local step scaled by a power of two around the center octave.
   function automatic logic [PHASE_W-1:0] remote_step(input int n, input logic [OCT_W-1:0] oct);
      logic [PHASE_W-1:0] st;
      st = STEP_TABLE[n];
      if (oct > OCT_CENTER) begin
         return st << (oct - OCT_CENTER);
      end else if (oct < OCT_CENTER) begin
         return st >> (OCT_CENTER - oct);
      end
      return st;
   endfunction

endpackage

[hw/rtl/ptm_if.sv]
// Valid/ready channel interfaces for the mixer's request and response items.
interface ptm_req_if;
   logic                        valid;
   logic                        ready;
   logic [ptm_pkg::KEY_W-1:0]   local_keys;
   logic [ptm_pkg::KEY_W-1:0]   remote_keys;
   logic [ptm_pkg::OCT_W-1:0]   remote_octave;
   logic [ptm_pkg::VOL_W-1:0]   volume;

   modport source (output valid, output local_keys, output remote_keys,
                   output remote_octave, output volume, input ready);
   modport sink   (input valid, input local_keys, input remote_keys,
                   input remote_octave, input volume, output ready);
endinterface

interface ptm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptm_pkg::SAMPLE_W-1:0]  sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

[hw/rtl/ptm_lane.sv]
// One voice lane: a phase accumulator and its triangle wave lookup.
module ptm_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               key,
   input  logic [ptm_pkg::PHASE_W-1:0]        step,
   output logic                               active,
   output logic signed [ptm_pkg::WAVE_W-1:0]  wave
);

   logic [ptm_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                        active_ff, active_in;
   logic [7:0]                  top;
   logic [6:0]                  fold;

   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      if (advance) begin
         active_in = key;
         if (key) begin
            phase_in = phase_ff + step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
      end
   end

   // Fold the top byte into 0..127, then map to -128..126.
   assign top    = phase_ff[ptm_pkg::PHASE_W-1 -: 8];
   assign fold   = top[7] ? ~top[6:0] : top[6:0];
   assign wave   = $signed({fold, 1'b0}) ^ $signed(8'h80);
   assign active = active_ff;

endmodule

[hw/rtl/ptm_merge.sv]
// Two-stage registered adder tree that sums lane waves and counts sounding voices.
module ptm_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [ptm_pkg::WAVE_W-1:0]  wave [ptm_pkg::LANE_COUNT],
   input  logic                               active [ptm_pkg::LANE_COUNT],
   output ptm_pkg::merge_result_type          result
);

   logic signed [ptm_pkg::GSUM_W-1:0] gsum_ff [ptm_pkg::GROUP_COUNT];
   logic signed [ptm_pkg::GSUM_W-1:0] gsum_in [ptm_pkg::GROUP_COUNT];
   logic [ptm_pkg::GCNT_W-1:0]        gcnt_ff [ptm_pkg::GROUP_COUNT];
   logic [ptm_pkg::GCNT_W-1:0]        gcnt_in [ptm_pkg::GROUP_COUNT];
   logic                              stage_a_ff;
   logic signed [ptm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [ptm_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              done_ff;

   always_comb begin
      for (int g = 0; g < ptm_pkg::GROUP_COUNT; g++) begin
         gsum_in[g] = '0;
         gcnt_in[g] = '0;
         for (int k = 0; k < ptm_pkg::GROUP_SIZE; k++) begin
            if (g * ptm_pkg::GROUP_SIZE + k < ptm_pkg::LANE_COUNT) begin
               if (active[g * ptm_pkg::GROUP_SIZE + k]) begin
                  gsum_in[g] = gsum_in[g]
                             + ptm_pkg::GSUM_W'(wave[g * ptm_pkg::GROUP_SIZE + k]);
                  gcnt_in[g] = gcnt_in[g] + ptm_pkg::GCNT_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      cnt_in = '0;
      for (int g = 0; g < ptm_pkg::GROUP_COUNT; g++) begin
         sum_in = sum_in + ptm_pkg::SUM_W'(gsum_ff[g]);
         cnt_in = cnt_in + ptm_pkg::CNT_W'(gcnt_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         gsum_ff <= gsum_in;
         gcnt_ff <= gcnt_in;
      end
      if (stage_a_ff) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         stage_a_ff <= go;
         done_ff    <= stage_a_ff;
      end
   end

   assign result.done   = done_ff;
   assign result.sum    = sum_ff;
   assign result.voices = cnt_ff;

endmodule

[hw/rtl/ptm_divider.sv]
// Restoring divider: one quotient bit per cycle of magnitude by voice count.
module ptm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptm_pkg::MAG_W-1:0]     dividend,
   input  logic [ptm_pkg::CNT_W-1:0]     divisor,
   output ptm_pkg::div_result_type       result
);

   localparam int ITER_W = $clog2(ptm_pkg::MAG_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ITER_W-1:0]           count_ff, count_in;
   logic [ptm_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [ptm_pkg::MAG_W-1:0]   quo_ff, quo_in;
   logic [ptm_pkg::CNT_W-1:0]   divisor_ff, divisor_in;
   logic [ptm_pkg::CNT_W:0]     trial;
   logic [ptm_pkg::CNT_W:0]     diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[ptm_pkg::MAG_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[ptm_pkg::CNT_W-1:0] : trial[ptm_pkg::CNT_W-1:0];
         quo_in   = {quo_ff[ptm_pkg::MAG_W-2:0], fits};
         count_in = count_ff + ITER_W'(1);
         if (count_ff == ITER_W'(ptm_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

[hw/rtl/polyphonic_triangle_mixer.sv]
// Polyphonic triangle mixer: 24 phase accumulator lanes, adder tree, divider, output stage.
// The voice-count divider dominates the time per item, and a new request is taken only after
// the previous item has left the control sequence.
// A finished sample waits in the output register; the next request is taken meanwhile.
// Synchronous reset clears all phase accumulators to zero and empties the pipeline.
module polyphonic_triangle_mixer (
   input  logic      clock,
   input  logic      reset,
   ptm_req_if.sink   req,
   ptm_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic                                go_ff;
   logic                                accept;
   logic [ptm_pkg::VOL_W-1:0]           vol_ff, vol_in;
   logic                                neg_ff, neg_in;
   logic                                silent_ff, silent_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ptm_pkg::SAMPLE_W-1:0]        sample_ff, sample_in;
   logic                                load;

   logic signed [ptm_pkg::WAVE_W-1:0]   wave [ptm_pkg::LANE_COUNT];
   logic                                active [ptm_pkg::LANE_COUNT];
   ptm_pkg::merge_result_type           merge_res;
   ptm_pkg::div_result_type             div_res;

   logic signed [ptm_pkg::SUM_W-1:0]    sum_val;
   logic [ptm_pkg::SUM_W-1:0]           sum_abs;
   logic signed [ptm_pkg::SUM_W-1:0]    quo_mag;
   logic signed [ptm_pkg::SUM_W-1:0]    quo_signed;
   logic signed [ptm_pkg::SUM_W-1:0]    shifted;
   logic [ptm_pkg::VOL_W-1:0]           shift_amt;
   logic signed [ptm_pkg::SUM_W:0]      biased;
   logic [ptm_pkg::SAMPLE_W-1:0]        final_sample;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   for (genvar i = 0; i < ptm_pkg::ACTIVE_NOTES; i++) begin : g_lane
      ptm_lane u_local_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (accept),
         .key     (req.local_keys[i]),
         .step    (ptm_pkg::STEP_TABLE[i]),
         .active  (active[i]),
         .wave    (wave[i])
      );
      ptm_lane u_remote_lane (
         .clock   (clock),
         .reset   (reset),
         .advance (accept),
         .key     (req.remote_keys[i]),
         .step    (ptm_pkg::remote_step(i, req.remote_octave)),
         .active  (active[ptm_pkg::ACTIVE_NOTES + i]),
         .wave    (wave[ptm_pkg::ACTIVE_NOTES + i])
      );
   end

   ptm_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .go     (go_ff),
      .wave   (wave),
      .active (active),
      .result (merge_res)
   );

   assign sum_val = $signed(merge_res.sum);
   assign sum_abs = sum_val[ptm_pkg::SUM_W-1] ? ptm_pkg::SUM_W'(-sum_val) : merge_res.sum;

   ptm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (merge_res.done),
      .dividend (sum_abs[ptm_pkg::MAG_W-1:0]),
      .divisor  (merge_res.voices),
      .result   (div_res)
   );

   // Restore the sign (truncation toward zero), apply volume as a floor shift, then clamp.
   always_comb begin
      quo_mag    = $signed({1'b0, div_res.quotient});
      quo_signed = neg_ff ? -quo_mag : quo_mag;
      shift_amt  = (vol_ff > ptm_pkg::MAX_VOLUME) ? '0 : ptm_pkg::MAX_VOLUME - vol_ff;
      shifted    = quo_signed >>> shift_amt;
      biased     = ptm_pkg::SUM_W'(shifted) + (ptm_pkg::SUM_W + 1)'(ptm_pkg::SAMPLE_MID);
      if (silent_ff) begin
         final_sample = ptm_pkg::SAMPLE_W'(ptm_pkg::SAMPLE_MID);
      end else if (biased < 0) begin
         final_sample = '0;
      end else if (biased > ptm_pkg::SAMPLE_MAX) begin
         final_sample = ptm_pkg::SAMPLE_W'(ptm_pkg::SAMPLE_MAX);
      end else begin
         final_sample = biased[ptm_pkg::SAMPLE_W-1:0];
      end
   end

   assign load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in  = state_ff;
      vol_in    = vol_ff;
      neg_in    = neg_ff;
      silent_in = silent_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vol_in   = req.volume;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (merge_res.done) begin
               neg_in    = sum_val[ptm_pkg::SUM_W-1];
               silent_in = (merge_res.voices == '0);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         sample_in    = final_sample;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      vol_ff    <= vol_in;
      neg_ff    <= neg_in;
      silent_ff <= silent_in;
      sample_ff <= sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = sample_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the polyphonic triangle mixer, with its own phase-accumulator model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ptm_pkg::*;

   localparam int RANDOM_TICKS   = 400;
   localparam int HALF_TICKS     = RANDOM_TICKS / 2;
   localparam int MAX_GAP        = 19;
   localparam int BURST_FIRST    = 60;
   localparam int BURST_LAST     = 110;
   localparam int FAST_FIRST     = 250;
   localparam int FAST_LAST      = 300;
   localparam int HOLD_AT_RESULT = 120;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct {
      logic [KEY_W-1:0] local_keys;
      logic [KEY_W-1:0] remote_keys;
      logic [OCT_W-1:0] remote_octave;
      logic [VOL_W-1:0] volume;
      int               gap;
   } tick_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptm_req_if req ();
   ptm_rsp_if rsp ();

   polyphonic_triangle_mixer dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   logic [PHASE_W-1:0]  local_acc  [ACTIVE_NOTES];
   logic [PHASE_W-1:0]  remote_acc [ACTIVE_NOTES];
   tick_item_t          pending_ticks [$];
   logic [SAMPLE_W-1:0] expected_samples [$];
   tick_item_t          offered;
   bit                  offering = 1'b0;
   int                  gap_count = 0;
   int                  results_seen = 0;
   int                  stall_left = 0;
   int                  hold_left = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Triangle of the top phase byte: rises over the first half, falls over the second.
   function automatic int wave_of(input logic [PHASE_W-1:0] phase);
      logic [7:0] top;
      top = phase[PHASE_W-1 -: 8];
      if (top >= 8'd128) begin
         top = 8'd255 - top;
      end
      return 2 * int'(top) - WAVE_SPAN;
   endfunction

   // Advances the sounding accumulators and returns the mixed sample of one tick.
   function automatic logic [SAMPLE_W-1:0] mix_sample(input tick_item_t t);
      int                 mix;
      int                 voices;
      int                 level;
      int                 shift;
      logic [PHASE_W-1:0] step;
      mix = 0;
      voices = 0;
      for (int n = 0; n < ACTIVE_NOTES; n++) begin
         if (t.local_keys[n]) begin
            local_acc[n] = local_acc[n] + STEP_TABLE[n];
            mix += wave_of(local_acc[n]);
            voices++;
         end
      end
      for (int n = 0; n < ACTIVE_NOTES; n++) begin
         if (t.remote_keys[n]) begin
            step = STEP_TABLE[n];
            if (t.remote_octave > OCT_CENTER) begin
               step = step << (t.remote_octave - OCT_CENTER);
            end else if (t.remote_octave < OCT_CENTER) begin
               step = step >> (OCT_CENTER - t.remote_octave);
            end
            remote_acc[n] = remote_acc[n] + step;
            mix += wave_of(remote_acc[n]);
            voices++;
         end
      end
      if (voices == 0) begin
         return SAMPLE_W'(SAMPLE_MID);
      end
      shift = (t.volume > MAX_VOLUME) ? 0 : int'(MAX_VOLUME - t.volume);
      // Integer division truncates toward zero; the shift that follows floors.
      level = ((mix / voices) >>> shift) + SAMPLE_MID;
      if (level < 0) begin
         level = 0;
      end
      if (level > SAMPLE_MAX) begin
         level = SAMPLE_MAX;
      end
      return SAMPLE_W'(level);
   endfunction

   function automatic logic [KEY_W-1:0] random_keys();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
         2: return KEY_W'($urandom) & KEY_W'($urandom) & KEY_W'($urandom);
         3: return '1;
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Mostly the intended 0..8, now and then the out-of-range codes above it.
   function automatic logic [3:0] random_level();
      if ($urandom_range(0, 7) == 0) begin
         return 4'($urandom_range(9, 15));
      end
      return 4'($urandom_range(0, 8));
   endfunction

   task automatic queue_tick(input logic [KEY_W-1:0] lk, input logic [KEY_W-1:0] rk,
                             input logic [OCT_W-1:0] oct, input logic [VOL_W-1:0] vol,
                             input int gap);
      tick_item_t t;
      t.local_keys = lk;
      t.remote_keys = rk;
      t.remote_octave = oct;
      t.volume = vol;
      t.gap = gap;
      pending_ticks.push_back(t);
   endtask

   task automatic wait_all_delivered();
      while (pending_ticks.size() != 0 || offering || expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver: each item waits out its own gap before it is offered.
   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < ACTIVE_NOTES; n++) begin
            local_acc[n] = '0;
            remote_acc[n] = '0;
         end
         offered = '{default: 0};
         offering = 1'b0;
         gap_count = 0;
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_samples.push_back(mix_sample(offered));
            offering = 1'b0;
         end
         if (!offering && pending_ticks.size() != 0) begin
            if (gap_count < pending_ticks[0].gap) begin
               gap_count++;
            end else begin
               offered = pending_ticks.pop_front();
               offering = 1'b1;
               gap_count = 0;
            end
         end
         req.valid <= offering;
         req.local_keys <= offered.local_keys;
         req.remote_keys <= offered.remote_keys;
         req.remote_octave <= offered.remote_octave;
         req.volume <= offered.volume;
      end
   end

   // Response monitor: checks each sample and stalls at random, once for a long stretch.
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] wanted;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               $display("%0t: sample_out expected none, actual %0d", $time, rsp.sample_out);
            end else begin
               wanted = expected_samples.pop_front();
               if (rsp.sample_out !== wanted) begin
                  mismatch_count++;
                  $display("%0t: sample_out expected %0d, actual %0d",
                           $time, wanted, rsp.sample_out);
               end
            end
            results_seen++;
            if (results_seen == HOLD_AT_RESULT) begin
               hold_left = HOLD_CYCLES;
            end
            stall_left = (results_seen >= FAST_FIRST && results_seen < FAST_LAST) ?
                         0 : $urandom_range(0, MAX_GAP);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.local_keys = '0;
      req.remote_keys = '0;
      req.remote_octave = '0;
      req.volume = '0;
      rsp.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Silence, full chords, octave and volume extremes, out-of-range codes.
      queue_tick('0, '0, OCT_CENTER, MAX_VOLUME, 0);
      queue_tick('1, '0, OCT_CENTER, MAX_VOLUME, 0);
      queue_tick('0, '1, 4'd8, MAX_VOLUME, 3);
      queue_tick('0, '1, 4'd0, MAX_VOLUME, 0);
      queue_tick('1, '1, 4'd15, 4'd15, 7);
      queue_tick('1, '1, 4'd9, 4'd0, 0);
      queue_tick('1, '0, OCT_CENTER, 4'd1, 1);
      queue_tick('0, '1, 4'd11, 4'd7, 0);
      queue_tick('0, '0, 4'd15, 4'd0, 2);
      // One key per bank walking across the notes.
      for (int n = 0; n < KEY_W; n++) begin
         queue_tick(KEY_W'(1) << n, KEY_W'(1) << (KEY_W - 1 - n), OCT_W'(n),
                    VOL_W'(n % 9), $urandom_range(0, MAX_GAP));
      end
      wait_all_delivered();

      for (int i = 0; i < RANDOM_TICKS; i++) begin
         if (i == HALF_TICKS) begin
            wait_all_delivered();
         end
         queue_tick(random_keys(), random_keys(), random_level(), random_level(),
                    (i >= BURST_FIRST && i < BURST_LAST) ? 0 : $urandom_range(0, MAX_GAP));
      end
      wait_all_delivered();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
